// ----- rtl/core/mel_pkg.sv -----
// Shared constants, types and helper functions of the expression lexer.
package mel_pkg;

  localparam int MAX_CHARS     = 256;
  localparam int NAME_SLOTS    = 8;
  localparam int MANTISSA_BITS = 40;

  localparam int CP_W    = $clog2(MAX_CHARS + 1);
  localparam int TS_W    = $clog2(MAX_CHARS);
  localparam int LEN_W   = $clog2(NAME_SLOTS + 1);
  localparam int IDX_W   = $clog2(NAME_SLOTS);
  localparam int KIND_W  = 4;
  localparam int CODE_W  = 4;
  localparam int MANT_W  = 40;
  localparam int FRAC_W  = 4;
  localparam int POS_W   = 8;
  localparam int FRAC_MAX = 15;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 4'd1;
  localparam logic [KIND_W-1:0] KIND_FUNCTION = 4'd2;
  localparam logic [KIND_W-1:0] KIND_VARIABLE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LBRACKET = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RBRACKET = 4'd7;
  localparam logic [KIND_W-1:0] KIND_BAR      = 4'd8;
  localparam logic [KIND_W-1:0] KIND_END      = 4'd9;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 4'd10;

  localparam logic [CODE_W-1:0] OP_PLUS   = 4'd0;
  localparam logic [CODE_W-1:0] OP_MINUS  = 4'd1;
  localparam logic [CODE_W-1:0] OP_TIMES  = 4'd2;
  localparam logic [CODE_W-1:0] OP_DIVIDE = 4'd3;
  localparam logic [CODE_W-1:0] OP_POWER  = 4'd4;

  localparam logic [CODE_W-1:0] FN_ABS    = 4'd0;
  localparam logic [CODE_W-1:0] FN_SIN    = 4'd1;
  localparam logic [CODE_W-1:0] FN_SQRT   = 4'd2;
  localparam logic [CODE_W-1:0] FN_LOG    = 4'd3;
  localparam logic [CODE_W-1:0] FN_COS    = 4'd4;
  localparam logic [CODE_W-1:0] FN_TAN    = 4'd5;
  localparam logic [CODE_W-1:0] FN_EXP    = 4'd6;
  localparam logic [CODE_W-1:0] FN_ENTIER = 4'd7;
  localparam logic [CODE_W-1:0] FN_NEGATE = 4'd8;
  localparam logic [CODE_W-1:0] FN_SINC   = 4'd9;

  localparam logic [CODE_W-1:0] ERR_UNKNOWN_NAME = 4'd0;
  localparam logic [CODE_W-1:0] ERR_SECOND_POINT = 4'd1;
  localparam logic [CODE_W-1:0] ERR_ILLEGAL_CHAR = 4'd2;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW     = 4'd3;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_STAR       = "*";
  localparam logic [7:0] CH_SLASH      = "/";
  localparam logic [7:0] CH_CARET      = "^";
  localparam logic [7:0] CH_LPAREN     = "(";
  localparam logic [7:0] CH_RPAREN     = ")";
  localparam logic [7:0] CH_LBRACKET   = "[";
  localparam logic [7:0] CH_RBRACKET   = "]";
  localparam logic [7:0] CH_BAR        = "|";
  localparam logic [7:0] CH_POINT      = ".";
  localparam logic [7:0] CH_COMMA      = ",";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_DIGIT_0    = "0";
  localparam logic [7:0] CH_DIGIT_9    = "9";
  localparam logic [7:0] CH_LOWER_A    = "a";
  localparam logic [7:0] CH_LOWER_E    = "e";
  localparam logic [7:0] CH_LOWER_X    = "x";
  localparam logic [7:0] CH_LOWER_Z    = "z";
  localparam logic [7:0] CH_UPPER_A    = "A";
  localparam logic [7:0] CH_UPPER_E    = "E";
  localparam logic [7:0] CH_UPPER_X    = "X";
  localparam logic [7:0] CH_UPPER_Z    = "Z";

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_NUMBER = 5'b00010,
    MODE_NAME   = 5'b00100,
    MODE_PENDX  = 5'b01000,
    MODE_HALT   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [CODE_W-1:0] token_code;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction_digits;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic              last_of_run;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0] tok;
    logic [CNT_W-1:0]   count;
  } batch_t;

  typedef logic [NAME_SLOTS-1:0][7:0] name_buf_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } name_hit_t;

  localparam int NAME_ENTRIES = 19;
  localparam int NAME_TEXT_W  = 6;

  localparam logic [7:0] NAME_TEXT [NAME_ENTRIES][NAME_TEXT_W] = '{
    '{"a", "b", "s", CH_NUL, CH_NUL, CH_NUL},
    '{"s", "i", "n", CH_NUL, CH_NUL, CH_NUL},
    '{"s", "q", "r", "t", CH_NUL, CH_NUL},
    '{"l", "o", "g", CH_NUL, CH_NUL, CH_NUL},
    '{"c", "o", "s", CH_NUL, CH_NUL, CH_NUL},
    '{"t", "a", "n", CH_NUL, CH_NUL, CH_NUL},
    '{"e", "x", "p", CH_NUL, CH_NUL, CH_NUL},
    '{"e", "n", "t", "i", "e", "r"},
    '{"_", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"s", "i", "n", "c", CH_NUL, CH_NUL},
    '{"A", "B", "S", CH_NUL, CH_NUL, CH_NUL},
    '{"S", "I", "N", CH_NUL, CH_NUL, CH_NUL},
    '{"S", "Q", "R", "T", CH_NUL, CH_NUL},
    '{"L", "O", "G", CH_NUL, CH_NUL, CH_NUL},
    '{"C", "O", "S", CH_NUL, CH_NUL, CH_NUL},
    '{"T", "A", "N", CH_NUL, CH_NUL, CH_NUL},
    '{"E", "X", "P", CH_NUL, CH_NUL, CH_NUL},
    '{"E", "N", "T", "I", "E", "R"},
    '{"S", "I", "N", "C", CH_NUL, CH_NUL}
  };

  localparam logic [3:0] NAME_LEN [NAME_ENTRIES] = '{
    4'd3, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd1, 4'd4,
    4'd3, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd6, 4'd4
  };

  localparam logic [CODE_W-1:0] NAME_CODE [NAME_ENTRIES] = '{
    FN_ABS, FN_SIN, FN_SQRT, FN_LOG, FN_COS, FN_TAN, FN_EXP, FN_ENTIER, FN_NEGATE,
    FN_SINC, FN_ABS, FN_SIN, FN_SQRT, FN_LOG, FN_COS, FN_TAN, FN_EXP, FN_ENTIER,
    FN_SINC
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
  endfunction

  function automatic tok_t make_tok(input logic [KIND_W-1:0] kind,
                                    input logic [CODE_W-1:0] code,
                                    input logic [MANT_W-1:0] mant,
                                    input logic [FRAC_W-1:0] frac,
                                    input logic [POS_W-1:0]  s,
                                    input logic [POS_W-1:0]  e);
    tok_t t;
    t.token_kind      = kind;
    t.token_code      = code;
    t.mantissa        = mant;
    t.fraction_digits = frac;
    t.start_pos       = s;
    t.end_pos         = e;
    t.last_of_run     = 1'b0;
    return t;
  endfunction

  // Only the first len characters of the buffer take part in the compare.
  function automatic name_hit_t name_lookup(input name_buf_t chars,
                                            input logic [LEN_W-1:0] len);
    name_hit_t r;
    logic      eq;
    r = '0;
    for (int e = 0; e < NAME_ENTRIES; e++) begin
      eq = (len == LEN_W'(NAME_LEN[e]));
      for (int i = 0; i < NAME_TEXT_W; i++) begin
        if (i < int'(NAME_LEN[e]) && chars[i] != NAME_TEXT[e][i]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        r.hit  = 1'b1;
        r.code = NAME_CODE[e];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mel_char_if.sv -----
// Character channel of the expression lexer.
interface mel_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ----- rtl/core/mel_tok_if.sv -----
// Token channel of the expression lexer.
interface mel_tok_if;
  import mel_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [CODE_W-1:0] token_code;
  logic [MANT_W-1:0] mantissa;
  logic [FRAC_W-1:0] fraction_digits;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  end_pos;
  logic              last_of_run;

  modport source (output valid, output token_kind, output token_code, output mantissa,
                  output fraction_digits, output start_pos, output end_pos,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_code, input mantissa,
                input fraction_digits, input start_pos, input end_pos,
                input last_of_run, output ready);
endinterface

// ----- rtl/core/mel_scan.sv -----
// Input register, scanner state and the combinational token decision per character.
module mel_scan (
  input  logic            clk,
  input  logic            rst,
  mel_char_if.sink        chars,
  output mel_pkg::batch_t batch,
  output logic            batch_valid,
  input  logic            batch_ready
);
  import mel_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eot;
  logic       advance;

  mode_t                    mode, mode_next;
  logic [MANTISSA_BITS-1:0] number_value, number_value_next;
  logic [FRAC_W-1:0]        fraction_count, fraction_count_next;
  logic                     point_seen, point_seen_next;
  name_buf_t                name_chars, name_chars_next;
  logic [LEN_W-1:0]         name_length, name_length_next;
  logic [TS_W-1:0]          token_start, token_start_next;
  logic [CP_W-1:0]          char_position, char_position_next;
  logic [7:0]               previous_char, previous_char_next;

  tok_t                     t_close, t_open, t_end;
  logic                     close_v, open_v, end_v;
  tok_t [MAX_RES-1:0]       cand;
  logic [MAX_RES-1:0]       cand_v;
  logic [CNT_W-1:0]         cnt;
  logic                     done;
  logic                     past_end, name_cont, is_x, after_e, num_ovf;
  logic [POS_W-1:0]         pos, pos_prev, last_pos, start_pos;
  logic [3:0]               digit;
  logic [MANTISSA_BITS+3:0] scaled;
  name_hit_t                hit_run, hit_eot;

  assign past_end  = char_position >= CP_W'(MAX_CHARS);
  assign pos       = POS_W'(char_position);
  assign pos_prev  = pos - 1'b1;
  assign last_pos  = past_end ? POS_W'(MAX_CHARS - 1) : pos;
  assign start_pos = POS_W'(token_start);
  assign is_x      = (s1_char == CH_LOWER_X) || (s1_char == CH_UPPER_X);
  assign after_e   = (previous_char == CH_LOWER_E) || (previous_char == CH_UPPER_E);
  assign name_cont = is_letter(s1_char) && !(is_x && !after_e) &&
                     (previous_char != CH_UNDERSCORE);
  assign digit     = s1_char[3:0];
  assign scaled    = ({4'b0000, number_value} << 3) + ({4'b0000, number_value} << 1) +
                     (MANTISSA_BITS + 4)'(digit);
  assign num_ovf   = |scaled[MANTISSA_BITS+3:MANTISSA_BITS];

  always_comb begin
    mode_next           = mode;
    number_value_next   = number_value;
    fraction_count_next = fraction_count;
    point_seen_next     = point_seen;
    name_chars_next     = name_chars;
    name_length_next    = name_length;
    token_start_next    = token_start;
    char_position_next  = char_position;
    previous_char_next  = previous_char;
    t_close = '0;
    t_open  = '0;
    t_end   = '0;
    close_v = 1'b0;
    open_v  = 1'b0;
    end_v   = 1'b0;
    hit_run = '0;
    hit_eot = '0;
    done    = 1'b0;

    if (mode != MODE_HALT && past_end) begin
      t_close   = make_tok(KIND_ERROR, ERR_OVERFLOW, '0, '0, last_pos, last_pos);
      close_v   = 1'b1;
      mode_next = MODE_HALT;
    end
    if (mode_next == MODE_HALT) begin
      done = 1'b1;
    end

    // A pending x becomes the first letter of a name when a letter follows.
    if (!done && mode_next == MODE_PENDX) begin
      if (is_letter(s1_char)) begin
        name_chars_next[0] = previous_char;
        name_length_next   = LEN_W'(1);
        mode_next          = MODE_NAME;
      end else begin
        t_close   = make_tok(KIND_VARIABLE, '0, '0, '0, start_pos, start_pos);
        close_v   = 1'b1;
        mode_next = MODE_IDLE;
      end
    end

    if (!done && mode_next == MODE_NAME) begin
      if (name_cont) begin
        if (name_length_next >= LEN_W'(NAME_SLOTS)) begin
          t_close   = make_tok(KIND_ERROR, ERR_OVERFLOW, '0, '0, start_pos, pos);
          close_v   = 1'b1;
          mode_next = MODE_HALT;
        end else begin
          name_chars_next[name_length_next[IDX_W-1:0]] = s1_char;
          name_length_next = name_length_next + 1'b1;
        end
        done = 1'b1;
      end else begin
        hit_run = name_lookup(name_chars_next, name_length_next);
        close_v = 1'b1;
        if (hit_run.hit) begin
          t_close   = make_tok(KIND_FUNCTION, hit_run.code, '0, '0, start_pos, pos_prev);
          mode_next = MODE_IDLE;
        end else begin
          t_close   = make_tok(KIND_ERROR, ERR_UNKNOWN_NAME, '0, '0, start_pos, pos_prev);
          mode_next = MODE_HALT;
          done      = 1'b1;
        end
      end
    end

    if (!done && mode_next == MODE_NUMBER) begin
      if (is_digit(s1_char)) begin
        if (num_ovf || (point_seen && fraction_count == FRAC_W'(FRAC_MAX))) begin
          t_close   = make_tok(KIND_ERROR, ERR_OVERFLOW, '0, '0, start_pos, pos);
          close_v   = 1'b1;
          mode_next = MODE_HALT;
        end else begin
          number_value_next = scaled[MANTISSA_BITS-1:0];
          if (point_seen) begin
            fraction_count_next = fraction_count + 1'b1;
          end
        end
        done = 1'b1;
      end else if (s1_char == CH_POINT || s1_char == CH_COMMA) begin
        if (point_seen) begin
          t_close   = make_tok(KIND_ERROR, ERR_SECOND_POINT, '0, '0, pos, pos);
          close_v   = 1'b1;
          mode_next = MODE_HALT;
        end else begin
          point_seen_next = 1'b1;
        end
        done = 1'b1;
      end else begin
        t_close   = make_tok(KIND_NUMBER, '0, MANT_W'(number_value), fraction_count,
                             start_pos, pos_prev);
        close_v   = 1'b1;
        mode_next = MODE_IDLE;
      end
    end

    if (!done && mode_next == MODE_IDLE) begin
      case (s1_char)
        CH_SPACE: begin
        end
        CH_PLUS: begin
          t_open = make_tok(KIND_OPERATOR, OP_PLUS, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_MINUS: begin
          t_open = make_tok(KIND_OPERATOR, OP_MINUS, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_STAR: begin
          t_open = make_tok(KIND_OPERATOR, OP_TIMES, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_SLASH: begin
          t_open = make_tok(KIND_OPERATOR, OP_DIVIDE, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_CARET: begin
          t_open = make_tok(KIND_OPERATOR, OP_POWER, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_LPAREN: begin
          t_open = make_tok(KIND_LPAREN, '0, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_RPAREN: begin
          t_open = make_tok(KIND_RPAREN, '0, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_LBRACKET: begin
          t_open = make_tok(KIND_LBRACKET, '0, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_RBRACKET: begin
          t_open = make_tok(KIND_RBRACKET, '0, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        CH_BAR: begin
          t_open = make_tok(KIND_BAR, '0, '0, '0, pos, pos);
          open_v = 1'b1;
        end
        default: begin
          token_start_next = TS_W'(char_position);
          if (is_digit(s1_char)) begin
            number_value_next   = MANTISSA_BITS'(digit);
            fraction_count_next = '0;
            point_seen_next     = 1'b0;
            mode_next           = MODE_NUMBER;
          end else if (is_x) begin
            mode_next = MODE_PENDX;
          end else if (is_letter(s1_char) || s1_char == CH_UNDERSCORE) begin
            name_chars_next[0] = s1_char;
            name_length_next   = LEN_W'(1);
            mode_next          = MODE_NAME;
          end else begin
            t_open    = make_tok(KIND_ERROR, ERR_ILLEGAL_CHAR, '0, '0, pos, pos);
            open_v    = 1'b1;
            mode_next = MODE_HALT;
          end
        end
      endcase
    end

    // The final character closes any open token and rearms the scanner.
    if (s1_eot) begin
      case (mode_next)
        MODE_NUMBER: begin
          t_open = make_tok(KIND_NUMBER, '0, MANT_W'(number_value_next), fraction_count_next,
                            POS_W'(token_start_next), last_pos);
          open_v = 1'b1;
        end
        MODE_NAME: begin
          hit_eot = name_lookup(name_chars_next, name_length_next);
          open_v  = 1'b1;
          if (hit_eot.hit) begin
            t_open = make_tok(KIND_FUNCTION, hit_eot.code, '0, '0,
                              POS_W'(token_start_next), last_pos);
          end else begin
            t_open = make_tok(KIND_ERROR, ERR_UNKNOWN_NAME, '0, '0,
                              POS_W'(token_start_next), last_pos);
          end
        end
        MODE_PENDX: begin
          t_open = make_tok(KIND_VARIABLE, '0, '0, '0, POS_W'(token_start_next),
                            POS_W'(token_start_next));
          open_v = 1'b1;
        end
        default: begin
        end
      endcase
      t_end               = make_tok(KIND_END, '0, '0, '0, last_pos, last_pos);
      end_v               = 1'b1;
      mode_next           = MODE_IDLE;
      number_value_next   = '0;
      fraction_count_next = '0;
      point_seen_next     = 1'b0;
      name_length_next    = '0;
      token_start_next    = '0;
      char_position_next  = '0;
      previous_char_next  = '0;
    end else begin
      previous_char_next = s1_char;
      if (!past_end) begin
        char_position_next = char_position + 1'b1;
      end
    end
  end

  assign cand   = {t_end, t_open, t_close};
  assign cand_v = {end_v, open_v, close_v};

  always_comb begin
    batch = '0;
    cnt   = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      if (cand_v[k]) begin
        batch.tok[cnt] = cand[k];
        cnt = cnt + 1'b1;
      end
    end
    if (cnt != '0) begin
      batch.tok[cnt - 1'b1].last_of_run = 1'b1;
    end
    batch.count = cnt;
  end

  assign batch_valid = s1_valid && (batch.count != '0);
  assign advance     = s1_valid && ((batch.count == '0) || batch_ready);
  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      mode           <= MODE_IDLE;
      number_value   <= '0;
      fraction_count <= '0;
      point_seen     <= 1'b0;
      name_length    <= '0;
      token_start    <= '0;
      char_position  <= '0;
      previous_char  <= '0;
    end else begin
      if (chars.ready) begin
        s1_valid <= chars.valid;
      end
      if (advance) begin
        mode           <= mode_next;
        number_value   <= number_value_next;
        fraction_count <= fraction_count_next;
        point_seen     <= point_seen_next;
        name_length    <= name_length_next;
        token_start    <= token_start_next;
        char_position  <= char_position_next;
        previous_char  <= previous_char_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_eot  <= chars.end_of_text;
    end
    if (advance) begin
      name_chars <= name_chars_next;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    s1_valid && mode == MODE_HALT && !s1_eot |-> batch.count == '0)
    else $error("scanner produced a token after an error");

  a_eot_rearm: assert property (@(posedge clk) disable iff (rst)
    advance && s1_eot |=> mode == MODE_IDLE && char_position == '0)
    else $error("scanner not rearmed after the final character");

  a_name_len: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_NAME |-> name_length != '0 && name_length <= LEN_W'(NAME_SLOTS))
    else $error("name length out of range while a name is open");

endmodule

// ----- rtl/core/mel_queue.sv -----
// Result buffer: holds the tokens of one character and hands them out one per transaction.
module mel_queue (
  input  logic            clk,
  input  logic            rst,
  input  mel_pkg::batch_t batch,
  input  logic            batch_valid,
  output logic            batch_ready,
  mel_tok_if.source       tokens
);
  import mel_pkg::*;

  tok_t [MAX_RES-1:0] slots;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic               load;

  assign pop         = (count != '0) && tokens.ready;
  assign batch_ready = (count == '0) || ((count == CNT_W'(1)) && tokens.ready);
  assign load        = batch_valid && batch_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= batch.count;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= batch.tok;
    end else if (pop) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        slots[k] <= slots[k+1];
      end
    end
  end

  assign tokens.valid           = count != '0;
  assign tokens.token_kind      = slots[0].token_kind;
  assign tokens.token_code      = slots[0].token_code;
  assign tokens.mantissa        = slots[0].mantissa;
  assign tokens.fraction_digits = slots[0].fraction_digits;
  assign tokens.start_pos       = slots[0].start_pos;
  assign tokens.end_pos         = slots[0].end_pos;
  assign tokens.last_of_run     = slots[0].last_of_run;

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> slots[0].last_of_run == (count == CNT_W'(1)))
    else $error("last_of_run does not match the buffer fill");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    pop && !load && count > CNT_W'(1) |=> slots[0] == $past(slots[1]))
    else $error("buffer did not advance to the next token");

  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> count == $past(batch.count) && count != '0)
    else $error("buffer fill wrong after a load");

endmodule

// ----- rtl/core/math_expression_lexer_top.sv -----
// Top level of the expression lexer: character stream in, token stream out.
//
//   Port    Dir  Carries                                        Transaction
//   chars   in   char_code, end_of_text                         one character
//   tokens  out  token_kind, token_code, mantissa,              one token
//                fraction_digits, start_pos, end_pos, last_of_run
//
// A character is decided in the cycle after it is taken, so one character per cycle is
// accepted while each character yields at most one token and tokens.ready stays high.
// A character that yields two or three tokens holds the input while the result buffer
// drains them, one token per cycle while tokens.ready is high.
// Reset is synchronous and returns the scanner to the start of an expression.
// Tokens wait in the result buffer while tokens.ready is low; characters that yield no
// token keep flowing meanwhile.
module math_expression_lexer_top (
  input  logic      clk,
  input  logic      rst,
  mel_char_if.sink  chars,
  mel_tok_if.source tokens
);
  import mel_pkg::*;

  batch_t batch;
  logic   batch_valid;
  logic   batch_ready;

  mel_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .batch       (batch),
    .batch_valid (batch_valid),
    .batch_ready (batch_ready)
  );

  mel_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .batch       (batch),
    .batch_valid (batch_valid),
    .batch_ready (batch_ready),
    .tokens      (tokens)
  );

endmodule
